### design/fsn_pkg.sv
// ----------------------------------------------------------------------------
// Filename slug normalizer package
// Character constants, register map, the fallback name and the result record
// used by the normalizer.
// ----------------------------------------------------------------------------
package fsn_pkg;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;
  localparam int LEN_W       = 10;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 10'd1023;

  // Register map, by word index.
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_present;
    logic       name_end;
  } result_t;

  // Fallback name used when nothing visible survives normalization.
  function automatic logic [6:0] fallback_char(input logic [1:0] idx);
    logic [6:0] c;
    case (idx)
      2'd0:    c = 7'h66;  // f
      2'd1:    c = 7'h69;  // i
      2'd2:    c = 7'h6C;  // l
      default: c = 7'h65;  // e
    endcase
    return c;
  endfunction

endpackage

### design/fsn_in_if.sv
// ----------------------------------------------------------------------------
// Name byte stream interface
// Valid/ready channel carrying one input byte of a name per beat.
// ----------------------------------------------------------------------------
interface fsn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       char_present;
  logic       end_of_text;

  modport source (output valid, ch, char_present, end_of_text, input ready);
  modport sink   (input valid, ch, char_present, end_of_text, output ready);
endinterface

### design/fsn_out_if.sv
// ----------------------------------------------------------------------------
// Slug character stream interface
// Valid/ready channel carrying one normalized character per beat.
// ----------------------------------------------------------------------------
interface fsn_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_present;
  logic       name_end;

  modport source (output valid, out_char, out_present, name_end, input ready);
  modport sink   (input valid, out_char, out_present, name_end, output ready);
endinterface

### design/filename_slug_normalizer.sv
// ----------------------------------------------------------------------------
// Filename slug normalizer
// Lowercases, collapses separators and trims a name byte stream into a slug.
// ----------------------------------------------------------------------------
// Timing: a byte's first result beat is offered in the cycle after acceptance.
// Throughput: one input beat per cycle while each byte yields at most one
//   result and slug_out is ready; a byte yielding k results (up to 4) holds
//   further input until its queue drains, one beat per cycle while slug_out is ready.
// Reset: synchronous rst clears the name state and the result queue and sets
//   max_length to 1023; no clearing pass is needed.
module filename_slug_normalizer #(
  parameter int NAME_BUFFER = 1024
) (
  input  logic        clk,
  input  logic        rst,
  fsn_in_if.sink      name_in,
  fsn_out_if.source   slug_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAP_W = $clog2(NAME_BUFFER);
  localparam int CMP_W = (CAP_W > fsn_pkg::LEN_W) ? CAP_W : fsn_pkg::LEN_W;
  localparam logic [CMP_W-1:0] LIMIT_CAP = CMP_W'(NAME_BUFFER - 1);

  // Configuration
  logic [fsn_pkg::LEN_W-1:0] max_length;
  logic [fsn_pkg::LEN_W-1:0] limit;
  logic                      cfg_wr;

  // Name state
  logic                      prev_separator;
  logic [7:0]                pending_sep_char;
  logic                      pending_sep_valid;
  logic [fsn_pkg::LEN_W-1:0] chars_counted;
  logic                      any_visible_out;
  logic                      saw_input_byte;

  // Result queue, slot 0 is presented on the output
  fsn_pkg::result_t          rq [fsn_pkg::MAX_RESULTS];
  logic [fsn_pkg::CNT_W-1:0] rq_cnt;

  // Per-byte decode
  logic                      accept;
  logic                      pop;
  logic                      is_sep;
  logic [7:0]                mapped;
  logic                      take;
  logic                      emit_char;
  logic                      saw_next;
  logic                      vis_next;
  fsn_pkg::result_t          res [fsn_pkg::MAX_RESULTS];
  logic [fsn_pkg::CNT_W-1:0] res_n;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == fsn_pkg::REG_MAX_LENGTH) ?
                  {{(32 - fsn_pkg::LEN_W){1'b0}}, max_length} : 32'd0;

  assign limit = ({{(CMP_W - fsn_pkg::LEN_W){1'b0}}, max_length} > LIMIT_CAP) ?
                 LIMIT_CAP[fsn_pkg::LEN_W-1:0] : max_length;

  assign pop           = slug_out.valid && slug_out.ready;
  assign name_in.ready = (rq_cnt == '0) || ((rq_cnt == 3'd1) && slug_out.ready);
  assign accept        = name_in.valid && name_in.ready;

  always_comb begin
    is_sep = 1'b0;
    mapped = name_in.ch;
    case (name_in.ch) inside
      [8'h41:8'h5A]: mapped = name_in.ch + 8'd32;
      [8'h61:8'h7A], [8'h30:8'h39]: mapped = name_in.ch;
      fsn_pkg::CH_DOT, fsn_pkg::CH_DASH, fsn_pkg::CH_UNDER: is_sep = 1'b1;
      default: begin
        mapped = fsn_pkg::CH_DASH;
        is_sep = 1'b1;
      end
    endcase
  end

  assign take      = name_in.char_present && !(is_sep && prev_separator) &&
                     (chars_counted < limit);
  assign emit_char = take && !is_sep;
  assign saw_next  = saw_input_byte || name_in.char_present;
  assign vis_next  = any_visible_out || emit_char;

  always_comb begin
    for (int i = 0; i < fsn_pkg::MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    res_n = '0;
    if (emit_char) begin
      if (pending_sep_valid) begin
        res[0] = '{out_char: pending_sep_char[6:0], out_present: 1'b1, name_end: 1'b0};
        res[1] = '{out_char: mapped[6:0], out_present: 1'b1,
                   name_end: name_in.end_of_text};
        res_n  = 3'd2;
      end else begin
        res[0] = '{out_char: mapped[6:0], out_present: 1'b1,
                   name_end: name_in.end_of_text};
        res_n  = 3'd1;
      end
    end else if (name_in.end_of_text) begin
      if (saw_next && !vis_next) begin
        for (int i = 0; i < fsn_pkg::MAX_RESULTS; i++) begin
          res[i] = '{out_char: fsn_pkg::fallback_char(2'(i)), out_present: 1'b1,
                     name_end: (i == fsn_pkg::MAX_RESULTS - 1)};
        end
        res_n = 3'd4;
      end else begin
        // Empty name, or an end beat that adds no character of its own.
        res[0] = '{out_char: 7'd0, out_present: 1'b0, name_end: 1'b1};
        res_n  = 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= fsn_pkg::MAX_LENGTH_RESET;
    end else if (cfg_wr && (paddr[2] == fsn_pkg::REG_MAX_LENGTH)) begin
      max_length <= pwdata[fsn_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_separator    <= 1'b0;
      pending_sep_char  <= '0;
      pending_sep_valid <= 1'b0;
      chars_counted     <= '0;
      any_visible_out   <= 1'b0;
      saw_input_byte    <= 1'b0;
    end else if (accept) begin
      if (name_in.end_of_text) begin
        prev_separator    <= 1'b0;
        pending_sep_char  <= '0;
        pending_sep_valid <= 1'b0;
        chars_counted     <= '0;
        any_visible_out   <= 1'b0;
        saw_input_byte    <= 1'b0;
      end else begin
        saw_input_byte <= saw_next;
        if (take) begin
          chars_counted  <= chars_counted + 1'b1;
          prev_separator <= is_sep;
          if (is_sep) begin
            // Leading separators count but are never held for output.
            if (any_visible_out) begin
              pending_sep_char  <= mapped;
              pending_sep_valid <= 1'b1;
            end
          end else begin
            pending_sep_valid <= 1'b0;
            any_visible_out   <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_cnt <= '0;
    end else if (accept) begin
      rq_cnt <= res_n;
    end else if (pop) begin
      rq_cnt <= rq_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rq <= res;
    end else if (pop) begin
      for (int i = 0; i < fsn_pkg::MAX_RESULTS - 1; i++) begin
        rq[i] <= rq[i+1];
      end
    end
  end

  assign slug_out.valid       = (rq_cnt != '0);
  assign slug_out.out_char    = rq[0].out_char;
  assign slug_out.out_present = rq[0].out_present;
  assign slug_out.name_end    = rq[0].name_end;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    rq_cnt <= 3'(fsn_pkg::MAX_RESULTS))
    else $error("result queue count out of range");

  a_accept_when_draining: assert property (@(posedge clk) disable iff (rst)
    accept |-> (rq_cnt == '0) || ((rq_cnt == 3'd1) && pop))
    else $error("input accepted while results were still queued");

  a_bare_marker_ends: assert property (@(posedge clk) disable iff (rst)
    (slug_out.valid && !slug_out.out_present) |->
      (slug_out.name_end && (slug_out.out_char == 7'd0)))
    else $error("bare end marker not marked as name end");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    (accept && name_in.end_of_text) |=>
      (chars_counted == '0) && !saw_input_byte && !pending_sep_valid)
    else $error("name state not cleared after end of name");

  a_pending_needs_visible: assert property (@(posedge clk) disable iff (rst)
    pending_sep_valid |-> any_visible_out)
    else $error("separator held before any visible character");

endmodule
